// ----- sv/sstep_pkg.sv -----
// Shared types, constants and helper functions for the serial setpoint speed stepper.
package sstep_pkg;

    // Item kinds carried on the input tuser bit.
    typedef enum logic {
        ACT_BYTE = 1'b0,
        ACT_TICK = 1'b1
    } action_t;

    // Configuration register word indexes (byte address divided by four).
    typedef enum logic {
        REG_SETPOINT_LIMIT = 1'b0,
        REG_DUTY_MAX       = 1'b1
    } reg_idx_t;

    // Frame delimiter and ASCII zero.
    localparam logic [7:0]        STAR_CHAR = 8'h2A;
    localparam logic signed [15:0] ZERO_CHAR = 16'sd48;

    // Register reset values.
    localparam logic [7:0] SETPOINT_LIMIT_RESET = 8'd180;
    localparam logic [9:0] DUTY_MAX_RESET       = 10'd1023;

    // Speed is count*600/360 = count*5/3. It is computed as
    // (count*3415) >> 11, which is exact for every 8-bit count.
    localparam logic [11:0] SPEED_MUL   = 12'd3415;
    localparam int          SPEED_SHIFT = 11;

    // Signed width of the decimal frame total (up to three digits).
    localparam int TOTAL_W = 16;

    // Decimal weight of a digit position.
    function automatic int pow10(input int n);
        int r;
        r = 1;
        for (int k = 0; k < 3; k++) begin
            if (k < n) begin
                r = r * 10;
            end
        end
        return r;
    endfunction

endpackage

// ----- sv/serial_setpoint_speed_stepper_unit.sv -----
// Top level of the serial setpoint speed stepper: frame parser, speed and duty stepper.
//
// The block takes one word per clock on its input stream, unless the output stalls it,
// and gives one result word per accepted word. A word passes an input register and then
// the result register before its result is offered; the block sustains one word per
// cycle when the output side is ready. A byte word feeds the star-delimited
// decimal frame parser; a closing star loads the clamped setpoint and raises m_tuser.
// A tick word computes the speed as count*5/3 and moves the duty one step toward the
// setpoint, bounded by 0 and duty_max. Registers: setpoint_limit at byte address 0,
// duty_max at byte address 4.
module serial_setpoint_speed_stepper_unit
    import sstep_pkg::*;
#(
    parameter int DIGITS = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [15:8] pulse_count
    input  logic        s_tuser,   // [0] action
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [9:0] duty, [18:10] measured_speed,
                                   // [26:19] target_speed, [31:27] zero
    output logic        m_tuser,   // [0] target_loaded
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(DIGITS + 1);

    // Configuration registers.
    logic [7:0] setpoint_limit_reg;
    logic [9:0] duty_max_reg;
    reg_idx_t   cfg_idx;

    // Input stage.
    logic       in_valid_reg;
    action_t    in_action_reg;
    logic [7:0] in_rx_reg;
    logic [7:0] in_count_reg;

    // Block state.
    logic             in_frame_reg, in_frame_next;
    logic [CNT_W-1:0] digits_seen_reg, digits_seen_next;
    logic [7:0]       digit_reg [DIGITS];
    logic [7:0]       digit_next [DIGITS];
    logic [7:0]       target_reg, target_next;
    logic [9:0]       duty_reg, duty_next;
    logic [8:0]       speed_reg, speed_next;
    logic             loaded_next;

    // Result stage.
    logic       out_valid_reg;
    logic [9:0] out_duty_reg;
    logic [8:0] out_speed_reg;
    logic [7:0] out_target_reg;
    logic       out_loaded_reg;

    logic advance;

    // Working values.
    logic signed [TOTAL_W-1:0] total;
    logic [7:0]                frame_val;
    logic [19:0]               speed_prod;
    logic [8:0]                tick_speed;

    // Configuration access; registers are addressed by word.
    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_limit_reg <= SETPOINT_LIMIT_RESET;
            duty_max_reg       <= DUTY_MAX_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (cfg_idx)
                REG_SETPOINT_LIMIT: setpoint_limit_reg <= pwdata[7:0];
                REG_DUTY_MAX:       duty_max_reg       <= pwdata[9:0];
                default:            ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SETPOINT_LIMIT: prdata = {24'd0, setpoint_limit_reg};
            REG_DUTY_MAX:       prdata = {22'd0, duty_max_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // Pipeline flow: a word moves to the result register when it is free or being taken.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= action_t'(s_tuser);
            in_rx_reg     <= s_tdata[7:0];
            in_count_reg  <= s_tdata[15:8];
        end
    end

    // Decimal value of the stored frame, clamped to [0, setpoint_limit].
    always_comb begin
        total = '0;
        for (int i = 0; i < DIGITS; i++) begin
            if (CNT_W'(i) < digits_seen_reg) begin
                total = total + ($signed({8'd0, digit_reg[i]}) - ZERO_CHAR)
                        * TOTAL_W'(pow10(DIGITS - 1 - i));
            end
        end
        if (total[TOTAL_W-1]) begin
            frame_val = 8'd0;
        end else if (total[TOTAL_W-2:0] > (TOTAL_W-1)'(setpoint_limit_reg)) begin
            frame_val = setpoint_limit_reg;
        end else begin
            frame_val = total[7:0];
        end
    end

    // Speed of a tick word.
    assign speed_prod = 20'(in_count_reg * SPEED_MUL);
    assign tick_speed = speed_prod[SPEED_SHIFT +: 9];

    // Next state for the word in the input register.
    always_comb begin
        in_frame_next    = in_frame_reg;
        digits_seen_next = digits_seen_reg;
        digit_next       = digit_reg;
        target_next      = target_reg;
        duty_next        = duty_reg;
        speed_next       = speed_reg;
        loaded_next      = 1'b0;
        case (in_action_reg)
            ACT_BYTE: begin
                if (!in_frame_reg) begin
                    if (in_rx_reg == STAR_CHAR) begin
                        in_frame_next = 1'b1;
                    end
                end else if (in_rx_reg == STAR_CHAR) begin
                    target_next      = frame_val;
                    loaded_next      = 1'b1;
                    in_frame_next    = 1'b0;
                    digits_seen_next = '0;
                    for (int i = 0; i < DIGITS; i++) begin
                        digit_next[i] = 8'd0;
                    end
                end else if (digits_seen_reg < CNT_W'(DIGITS)) begin
                    for (int i = 0; i < DIGITS; i++) begin
                        if (digits_seen_reg == CNT_W'(i)) begin
                            digit_next[i] = in_rx_reg;
                        end
                    end
                    digits_seen_next = digits_seen_reg + 1'b1;
                end
            end
            ACT_TICK: begin
                speed_next = tick_speed;
                if ({1'b0, target_reg} > tick_speed) begin
                    if (duty_reg < duty_max_reg) begin
                        duty_next = duty_reg + 1'b1;
                    end
                end else if ({1'b0, target_reg} < tick_speed) begin
                    if (duty_reg != 10'd0) begin
                        duty_next = duty_reg - 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // State update as the word leaves the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg    <= 1'b0;
            digits_seen_reg <= '0;
            digit_reg       <= '{default: 8'd0};
            target_reg      <= 8'd0;
            duty_reg        <= 10'd0;
            speed_reg       <= 9'd0;
        end else if (advance) begin
            in_frame_reg    <= in_frame_next;
            digits_seen_reg <= digits_seen_next;
            digit_reg       <= digit_next;
            target_reg      <= target_next;
            duty_reg        <= duty_next;
            speed_reg       <= speed_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_duty_reg   <= duty_next;
            out_speed_reg  <= speed_next;
            out_target_reg <= target_next;
            out_loaded_reg <= loaded_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_target_reg, out_speed_reg, out_duty_reg};
    assign m_tuser  = out_loaded_reg;

endmodule

// ----- sv/sstep_chk.sv -----
// Port-level checker for the serial setpoint speed stepper and its bind statement.
module sstep_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // With the result register empty the input side always has room.
    a_in_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty result register");

    // An accepted word reaches the output when the output is taken while the word waits in the input register.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
        else $error("accepted word did not reach the output");

    // The measured speed never exceeds 255*5/3.
    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[18:10] <= 9'd425)
        else $error("measured speed out of range");

endmodule

bind serial_setpoint_speed_stepper_unit sstep_chk u_sstep_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- verif/serial_setpoint_speed_stepper_unit_test.sv -----
// Self-checking testbench for the serial setpoint speed stepper: stream traffic, APB setup, scoring.
module serial_setpoint_speed_stepper_unit_test
    import sstep_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_DIGITS = 3;
    localparam int SPEED_NUM    = 600;
    localparam int SPEED_DEN    = 360;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        action_t    act;
        logic [7:0] rx;
        logic [7:0] count;
    } stepper_word_t;

    typedef struct {
        logic [9:0] duty;
        logic [8:0] speed;
        logic [7:0] target;
        logic       loaded;
    } stepper_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [7:0] rx_byte, [15:8] pulse_count
    logic        s_tuser;   // [0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [9:0] duty, [18:10] measured_speed, [26:19] target_speed
    logic        m_tuser;   // [0] target_loaded
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    serial_setpoint_speed_stepper_unit #(
        .DIGITS(FRAME_DIGITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Words waiting to be sent and results still owed by the block.
    stepper_word_t   pending_words[$];
    stepper_result_t expected_results[$];
    stepper_word_t   next_word;

    // Predicted block state and register copies.
    logic       frame_open;
    int         chars_held;
    logic [7:0] frame_chars[FRAME_DIGITS];
    logic [7:0] setpoint;
    logic [9:0] duty_now;
    logic [8:0] speed_now;
    logic [7:0] limit_cfg;
    logic [9:0] duty_cap_cfg;

    // Traffic control and bookkeeping.
    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_off;
    logic word_taken;
    logic gen_open;
    int   mismatch_count;
    int   words_sent;
    int   ticks_seen;
    int   results_checked;
    int   loads_seen;
    int   cycle_count;

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Decimal value of the frame characters, floored at zero and clamped to the limit.
    function automatic logic [7:0] decoded_setpoint();
        int total;
        total = 0;
        for (int i = 0; i < FRAME_DIGITS; i++) begin
            total = total * 10;
            if (i < chars_held) begin
                total += int'(frame_chars[i]) - int'(ZERO_CHAR);
            end
        end
        if (total < 0) begin
            total = 0;
        end
        if (total > int'(limit_cfg)) begin
            total = int'(limit_cfg);
        end
        return 8'(total);
    endfunction

    // Advance the predicted state by one accepted word and return the result it causes.
    function automatic stepper_result_t advance_stepper(input action_t act,
                                                        input logic [7:0] rx,
                                                        input logic [7:0] count);
        stepper_result_t res;
        res.loaded = 1'b0;
        if (act == ACT_BYTE) begin
            if (!frame_open) begin
                if (rx == STAR_CHAR) begin
                    frame_open = 1'b1;
                end
            end else if (rx == STAR_CHAR) begin
                setpoint    = decoded_setpoint();
                res.loaded  = 1'b1;
                frame_open  = 1'b0;
                chars_held  = 0;
                frame_chars = '{default: 8'h00};
            end else if (chars_held < FRAME_DIGITS) begin
                frame_chars[chars_held] = rx;
                chars_held++;
            end
        end else begin
            ticks_seen++;
            speed_now = 9'((int'(count) * SPEED_NUM) / SPEED_DEN);
            if (setpoint > speed_now) begin
                if (duty_now < duty_cap_cfg) begin
                    duty_now++;
                end
            end else if (setpoint < speed_now) begin
                if (duty_now > 10'd0) begin
                    duty_now--;
                end
            end
        end
        res.duty   = duty_now;
        res.speed  = speed_now;
        res.target = setpoint;
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Driver: offers the next word once the current one is taken, and randomizes tready.
    always @(negedge aclk) begin
        if (!s_tvalid || word_taken) begin
            if (hold_off || pending_words.size() == 0 ||
                $urandom_range(0, 99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
            end else begin
                next_word = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_word.act;
                s_tdata  <= {next_word.count, next_word.rx};
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor and scoreboard: check results against the oldest expectation, then predict.
    always @(posedge aclk) begin
        stepper_result_t want;
        word_taken <= s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result word with no expectation pending: tdata %h", m_tdata);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("duty", want.duty, m_tdata[9:0]);
                check_field("measured_speed", want.speed, m_tdata[18:10]);
                check_field("target_speed", want.target, m_tdata[26:19]);
                check_field("target_loaded", want.loaded, m_tuser);
                results_checked++;
                if (m_tuser) begin
                    loads_seen++;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            expected_results.push_back(advance_stepper(action_t'(s_tuser),
                                                       s_tdata[7:0], s_tdata[15:8]));
            words_sent++;
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("serial_setpoint_speed_stepper_unit test failed");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        stepper_word_t w;
        w.act   = ACT_BYTE;
        w.rx    = b;
        w.count = 8'($urandom_range(0, 255));
        pending_words.push_back(w);
    endtask

    task automatic push_tick(input logic [7:0] c);
        stepper_word_t w;
        w.act   = ACT_TICK;
        w.rx    = 8'($urandom_range(0, 255));
        w.count = c;
        pending_words.push_back(w);
    endtask

    task automatic push_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            push_byte(txt[i]);
        end
    endtask

    // Mostly decimal digits, sometimes any other non-star byte.
    function automatic logic [7:0] random_char();
        logic [7:0] ch;
        if ($urandom_range(0, 99) < 85) begin
            ch = 8'h30 + 8'($urandom_range(0, 9));
        end else begin
            ch = 8'($urandom_range(0, 255));
            if (ch == STAR_CHAR) begin
                ch = 8'h2B;
            end
        end
        return ch;
    endfunction

    // Half the counts land near the usual setpoint range so the duty moves both ways.
    function automatic logic [7:0] random_count();
        if ($urandom_range(0, 1) == 0) begin
            return 8'($urandom_range(0, 110));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Random traffic: mostly well-formed frames and ticks, plus noise and unclosed frames.
    task automatic add_random(input int n);
        int made;
        int pick;
        int nch;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                push_tick(random_count());
                made++;
            end else if (pick < 85) begin
                if (gen_open) begin
                    push_byte(STAR_CHAR);
                    made++;
                end
                push_byte(STAR_CHAR);
                nch = $urandom_range(0, 5);
                for (int k = 0; k < nch; k++) begin
                    push_byte(random_char());
                    if ($urandom_range(0, 9) == 0) begin
                        push_tick(random_count());
                        made++;
                    end
                end
                push_byte(STAR_CHAR);
                made += nch + 2;
                gen_open = 1'b0;
            end else if (pick < 93) begin
                // A stray byte; outside a frame the block ignores it but still answers.
                push_byte(random_char());
                made++;
            end else begin
                if (!gen_open) begin
                    push_byte(STAR_CHAR);
                    made++;
                    gen_open = 1'b1;
                end
                nch = $urandom_range(1, 4);
                for (int k = 0; k < nch; k++) begin
                    push_byte(random_char());
                end
                made += nch;
            end
        end
    endtask

    // Wait until every queued word is sent and every expected word has come back.
    task automatic wait_drained();
        while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // APB write, then read back and compare.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] want;
        if (idx == REG_SETPOINT_LIMIT) begin
            want      = {24'd0, value[7:0]};
            limit_cfg = value[7:0];
        end else begin
            want         = {22'd0, value[9:0]};
            duty_cap_cfg = value[9:0];
        end
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        check_field("prdata", want, prdata);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Main sequence.
    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = 16'd0;
        s_tuser         = 1'b0;
        m_tready        = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = 3'd0;
        pwdata          = 32'd0;
        hold_off        = 1'b0;
        word_taken      = 1'b0;
        gen_open        = 1'b0;
        mismatch_count  = 0;
        words_sent      = 0;
        ticks_seen      = 0;
        results_checked = 0;
        loads_seen      = 0;
        cycle_count     = 0;
        frame_open      = 1'b0;
        chars_held      = 0;
        frame_chars     = '{default: 8'h00};
        setpoint        = 8'd0;
        duty_now        = 10'd0;
        speed_now       = 9'd0;
        limit_cfg       = SETPOINT_LIMIT_RESET;
        duty_cap_cfg    = DUTY_MAX_RESET;
        send_idle_pct   = 26;
        recv_idle_pct   = 86;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words under the reset register values.
        push_byte(8'hFF);
        push_text("A");
        push_text("**");
        push_tick(8'd0);
        push_tick(8'd255);
        push_text("*123*");
        push_tick(8'd1);
        push_text("*9995*");
        push_tick(8'd108);
        push_text("*7*");
        push_text("*!00*");
        push_tick(8'd255);
        wait_drained();

        // Widest limit, full duty range; sender pauses once mid-stream.
        write_reg(REG_SETPOINT_LIMIT, 32'd255);
        write_reg(REG_DUTY_MAX, 32'd1023);
        add_random(620);
        while (pending_words.size() > 300) begin
            @(posedge aclk);
        end
        hold_off = 1'b1;
        while (s_tvalid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (5) @(posedge aclk);
        hold_off = 1'b0;
        if (gen_open) begin
            push_byte(STAR_CHAR);
            gen_open = 1'b0;
        end
        // Push the duty well up before the ceiling is lowered.
        push_text("*255*");
        for (int i = 0; i < 30; i++) begin
            push_tick(8'd0);
        end
        wait_drained();

        // Duty now sits above the new ceiling, so upward steps are blocked.
        write_reg(REG_DUTY_MAX, 32'd1);
        for (int i = 0; i < 5; i++) begin
            push_tick(8'd0);
        end
        add_random(150);
        wait_drained();

        write_reg(REG_SETPOINT_LIMIT, 32'd0);
        add_random(80);
        wait_drained();

        // Receiver idles less than the sender; random register values.
        send_idle_pct = 86;
        recv_idle_pct = 26;
        write_reg(REG_SETPOINT_LIMIT, 32'($urandom_range(1, 254)));
        write_reg(REG_DUTY_MAX, 32'($urandom_range(2, 1022)));
        add_random(550);
        wait_drained();

        // Full throughput with reset-like values.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_SETPOINT_LIMIT, 32'd180);
        write_reg(REG_DUTY_MAX, 32'd1023);
        add_random(480);
        wait_drained();
        repeat (10) @(posedge aclk);

        $display("Sent %0d words (%0d ticks) and checked %0d results with %0d setpoint loads,",
                 words_sent, ticks_seen, results_checked, loads_seen);
        $display("across six limit and duty ceiling settings and three idle patterns.");
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("serial_setpoint_speed_stepper_unit test passed");
        end else begin
            $display("serial_setpoint_speed_stepper_unit test failed");
        end
        $finish;
    end

endmodule
